// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is applied
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/i2ctbt_pkg.sv =====
package i2ctbt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 8;
	localparam int OFF_W       = 3;

	// bus phase encoding: bit phases run from PH_BIT0 (bit 0 low) to PH_ACK_HIGH
	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_START    = 5'd1;
	localparam logic [4:0] PH_BIT0     = 5'd2;
	localparam logic [4:0] PH_ACK_HIGH = 5'd19;
	localparam logic [4:0] PH_IGNORE   = 5'd20;

	// register indexes on the configuration port
	localparam logic [1:0] REG_OWN_ADDR = 2'd0;
	localparam logic [1:0] REG_STRETCH  = 2'd1;
	localparam logic [1:0] REG_TABLE    = 2'd2;

	// register reset values
	localparam logic [6:0]  OWN_ADDR_RST = 7'h50;
	localparam logic [9:0]  STRETCH_RST  = 10'd10;
	localparam logic [63:0] TABLE_RST    = 64'hFF34_5623_AD00_13FA;

	typedef enum logic [1:0] {
		KIND_ADDR  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_STOP  = 2'd2,
		EV_ERROR = 2'd3
	} event_t;

	typedef struct packed {
		logic [6:0]  own_address;
		logic [9:0]  stretch_ticks;
		logic [63:0] table_bytes;
	} cfg_t;

	typedef struct packed {
		logic        sda_pull_low;
		logic        scl_hold_low;
		logic        byte_done;
		logic [7:0]  byte_value;
		kind_t       byte_kind;
		logic        byte_acked;
		event_t      bus_event;
	} res_t;

endpackage

// ===== rtl/i2ctbt_regs.sv =====
module i2ctbt_regs
	import i2ctbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [6:0]  own_address_q;
	logic [9:0]  stretch_ticks_q;
	logic [63:0] table_bytes_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:3];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= OWN_ADDR_RST;
			stretch_ticks_q <= STRETCH_RST;
			table_bytes_q   <= TABLE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OWN_ADDR: own_address_q   <= pwdata[6:0];
				REG_STRETCH:  stretch_ticks_q <= pwdata[9:0];
				REG_TABLE:    table_bytes_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_OWN_ADDR: prdata = {57'd0, own_address_q};
			REG_STRETCH:  prdata = {54'd0, stretch_ticks_q};
			REG_TABLE:    prdata = table_bytes_q;
			default:      prdata = 64'd0;
		endcase
	end

	assign cfg.own_address   = own_address_q;
	assign cfg.stretch_ticks = stretch_ticks_q;
	assign cfg.table_bytes   = table_bytes_q;

endmodule

// ===== rtl/i2ctbt_engine.sv =====
module i2ctbt_engine
	import i2ctbt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic scl,
	input  logic sda,
	input  cfg_t cfg,
	output res_t res
);

	// protocol state
	logic [4:0]     phase_q;
	logic [7:0]     shift_q;
	kind_t          kind_q;
	logic [OFF_W-1:0] offset_q;
	logic           owritten_q;
	logic           addressed_q;
	logic [9:0]     stretch_q;
	logic           last_scl_q;
	logic           last_sda_q;
	logic           ack_q;

	logic [4:0]     n_phase;
	logic [7:0]     n_shift;
	kind_t          n_kind;
	logic [OFF_W-1:0] n_offset;
	logic           n_owritten;
	logic           n_addressed;
	logic [9:0]     n_stretch;
	logic           n_ack;

	logic [3:0]     bit_b;
	logic [3:0]     n_bit_b;
	logic [3:0]     low_b;
	logic           go_low;
	logic           do_start;
	logic           do_idle;
	logic           in_bits;
	logic           n_in_bits;
	event_t         ev;
	logic           done;
	logic [7:0]     dval;
	kind_t          dkind;
	logic           dack;
	logic           pull;
	logic           hold;

	assign bit_b   = 4'((phase_q - PH_BIT0) >> 1);
	assign in_bits = (phase_q >= PH_BIT0) && (phase_q <= PH_ACK_HIGH);

	// next state for one line sample
	always_comb begin
		n_phase     = phase_q;
		n_shift     = shift_q;
		n_kind      = kind_q;
		n_offset    = offset_q;
		n_owritten  = owritten_q;
		n_addressed = addressed_q;
		n_stretch   = stretch_q;
		n_ack       = ack_q;
		ev          = EV_NONE;
		done        = 1'b0;
		dval        = 8'd0;
		dkind       = KIND_ADDR;
		dack        = 1'b0;
		go_low      = 1'b0;
		low_b       = 4'd0;
		do_start    = 1'b0;
		do_idle     = 1'b0;

		if (phase_q == PH_IDLE) begin
			// start needs both lines high on the previous sample
			if (last_scl_q && last_sda_q && !(scl && sda)) begin
				if (scl && !sda) begin
					do_start = 1'b1;
					ev       = EV_START;
				end else begin
					ev = EV_ERROR;
				end
			end
		end else if (phase_q == PH_START) begin
			if (!scl && !sda) begin
				go_low = 1'b1;
			end else if (scl && sda) begin
				do_idle = 1'b1;
				ev      = EV_STOP;
			end else if (!scl && sda) begin
				do_idle = 1'b1;
				ev      = EV_ERROR;
			end
		end else if (in_bits) begin
			if (!phase_q[0]) begin
				// scl low half: stretch, then wait for the rising edge
				if (stretch_q != 10'd0) begin
					n_stretch = stretch_q - 10'd1;
				end else if (scl) begin
					n_phase = phase_q + 5'd1;
					if (bit_b < 4'd8) begin
						if (kind_q != KIND_READ)
							n_shift = shift_q | (8'(sda) << (3'd7 - bit_b[2:0]));
					end else begin
						if (kind_q == KIND_READ) begin
							n_ack = ~sda;
							if (!sda)
								n_offset = (32'(offset_q) + 32'd1 >= 32'(TABLE_DEPTH)) ?
									'0 : offset_q + 1'b1;
						end else if (kind_q == KIND_WRITE) begin
							n_owritten = 1'b1;
						end
						done  = 1'b1;
						dval  = shift_q;
						dkind = kind_q;
						dack  = n_ack;
					end
				end
			end else begin
				// scl high half: falling edge moves on, sda change is start/stop
				if (!scl) begin
					if (bit_b < 4'd7) begin
						go_low = 1'b1;
						low_b  = bit_b + 4'd1;
					end else if (bit_b == 4'd7) begin
						case (kind_q)
							KIND_ADDR: begin
								n_ack = (shift_q[7:1] == cfg.own_address);
								if (n_ack)
									n_addressed = 1'b1;
							end
							KIND_WRITE: begin
								n_ack = !owritten_q && (shift_q < 8'(TABLE_DEPTH));
								if (n_ack)
									n_offset = shift_q[OFF_W-1:0];
							end
							default: n_ack = 1'b0;
						endcase
						go_low = 1'b1;
						low_b  = 4'd8;
					end else begin
						if (kind_q == KIND_ADDR) begin
							if (!addressed_q) begin
								n_phase = PH_IGNORE;
							end else begin
								n_kind = shift_q[0] ? KIND_READ : KIND_WRITE;
								go_low = 1'b1;
							end
						end else begin
							if (kind_q == KIND_READ && !ack_q)
								n_kind = KIND_WRITE;
							go_low = 1'b1;
						end
					end
				end else if (last_scl_q && (last_sda_q != sda)) begin
					if (last_sda_q) begin
						do_start = 1'b1;
						ev       = EV_START;
					end else begin
						do_idle = 1'b1;
						ev      = EV_STOP;
					end
				end
			end
		end else begin
			// bus released after a mismatch: only watch for start and stop
			if (last_scl_q && scl && (last_sda_q != sda)) begin
				if (last_sda_q) begin
					do_start = 1'b1;
					ev       = EV_START;
				end else begin
					do_idle = 1'b1;
					ev      = EV_STOP;
				end
			end else if (phase_q > PH_IGNORE) begin
				do_idle = 1'b1;
			end
		end

		// enter a new scl low phase
		if (go_low) begin
			n_phase   = PH_BIT0 + {low_b, 1'b0};
			n_stretch = cfg.stretch_ticks;
			if (low_b == 4'd0)
				n_shift = (n_kind == KIND_READ) ?
					cfg.table_bytes[{n_offset, 3'b000} +: 8] : 8'd0;
		end

		if (do_start || do_idle) begin
			n_phase     = do_start ? PH_START : PH_IDLE;
			n_kind      = KIND_ADDR;
			n_owritten  = 1'b0;
			n_addressed = 1'b0;
			n_ack       = 1'b0;
			if (do_idle)
				n_offset = '0;
		end
	end

	// line drive from the updated state
	assign n_bit_b   = 4'((n_phase - PH_BIT0) >> 1);
	assign n_in_bits = (n_phase >= PH_BIT0) && (n_phase <= PH_ACK_HIGH);

	always_comb begin
		pull = 1'b0;
		hold = 1'b0;
		if (n_in_bits) begin
			if (n_bit_b < 4'd8) begin
				if (n_kind == KIND_READ)
					pull = ~n_shift[3'd7 - n_bit_b[2:0]];
			end else if (n_kind != KIND_READ) begin
				pull = n_ack;
			end
			hold = !n_phase[0] && (n_stretch != 10'd0);
		end
	end

	assign res.sda_pull_low = pull;
	assign res.scl_hold_low = hold;
	assign res.byte_done    = done;
	assign res.byte_value   = dval;
	assign res.byte_kind    = dkind;
	assign res.byte_acked   = dack;
	assign res.bus_event    = ev;

	// state update once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= 8'd0;
			kind_q      <= KIND_ADDR;
			offset_q    <= '0;
			owritten_q  <= 1'b0;
			addressed_q <= 1'b0;
			stretch_q   <= 10'd0;
			last_scl_q  <= 1'b1;
			last_sda_q  <= 1'b1;
			ack_q       <= 1'b0;
		end else if (step) begin
			phase_q     <= n_phase;
			shift_q     <= n_shift;
			kind_q      <= n_kind;
			offset_q    <= n_offset;
			owritten_q  <= n_owritten;
			addressed_q <= n_addressed;
			stretch_q   <= n_stretch;
			last_scl_q  <= scl;
			last_sda_q  <= sda;
			ack_q       <= n_ack;
		end
	end

endmodule

// ===== rtl/i2c_target_byte_table_unit.sv =====
// I2C target answering reads from an eight-byte table.
// Input stream: one word per tick, the synchronized SCL and SDA samples.
// Output stream: one word per input word, with the SDA pull-down and SCL
// hold-low drives, a byte report (value, kind, acknowledge) on the tick SCL
// rises for the acknowledge bit, and a bus event code (start, stop, error).
// The APB port sets the own address, the stretch length and the table bytes;
// write it only while no words are in flight.
// Path: an accepted word is held in the input register, then processed by the
// state update, and its result sits in the output register until it is taken.
// Throughput: one word per cycle while the output is taken, set by the single
// state update per sample between the input register and the output register.
// Reset: the bus logic is idle with both lines taken as high, offset zero,
// registers at their defaults, both stream sides empty.
// Stall: while m_tready is low the result holds; one more word is kept in the
// input register, then s_tready drops until the output is taken.
module i2c_target_byte_table_unit
	import i2ctbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// line samples
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] scl_in, [1] sda_in, [7:2] zero
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] sda_pull_low, [1] scl_hold_low, [2] byte_done,
	                               // [10:3] byte_value, [11] byte_acked,
	                               // [13:12] bus_event, [15:14] zero
	output logic [1:0]  m_tuser,   // [1:0] byte_kind
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1;
	logic scl_s1;
	logic sda_s1;
	logic out_valid_q;
	logic advance;

	i2ctbt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			scl_s1 <= s_tdata[0];
			sda_s1 <= s_tdata[1];
		end
	end

	i2ctbt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.scl    (scl_s1),
		.sda    (sda_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.bus_event, res_q.byte_acked, res_q.byte_value,
		res_q.byte_done, res_q.scl_hold_low, res_q.sda_pull_low};
	assign m_tuser  = res_q.byte_kind;

endmodule

// ===== rtl/i2ctbt_checker.sv =====
`include "assert_macros.svh"

module i2ctbt_checker
	import i2ctbt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled word stays offered
	`CHK_ASSERT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")

	// a stalled word keeps its payload
	`CHK_ASSERT(a_hold_data, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// byte fields are zero unless a byte is reported
	`CHK_ASSERT(a_quiet_byte, clk, arst_n, m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0 && !m_tdata[11] && m_tuser == KIND_ADDR, "byte fields set without byte_done")

	// a byte report never coincides with a bus event
	`CHK_ASSERT(a_done_no_event, clk, arst_n, m_tvalid && m_tdata[2] |-> m_tdata[13:12] == EV_NONE, "byte report together with a bus event")

endmodule

bind i2c_target_byte_table_unit i2ctbt_checker u_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

import i2ctbt_pkg::*;

// predicts each output word of the byte table target and checks the returned words in order
class byte_table_scoreboard;
	logic [6:0]  own_addr;
	logic [9:0]  stretch;
	logic [63:0] tbl_bytes;

	logic [4:0]  phase;
	logic [7:0]  shreg;
	kind_t       kind;
	logic [2:0]  offset;
	bit          off_written;
	bit          addressed;
	bit          ack;
	logic [9:0]  count;
	logic [1:0]  last_lines;

	res_t        pending[$];
	int          n_words;
	int          n_errors;
	int          n_bytes[3];
	int          n_events[4];

	function new();
		own_addr   = OWN_ADDR_RST;
		stretch    = STRETCH_RST;
		tbl_bytes  = TABLE_RST;
		phase      = PH_IDLE;
		shreg      = '0;
		kind       = KIND_ADDR;
		offset     = '0;
		off_written = 0;
		addressed  = 0;
		ack        = 0;
		count      = '0;
		last_lines = 2'b11;
	endfunction

	function void set_reg(logic [1:0] idx, logic [63:0] val);
		case (idx)
			REG_OWN_ADDR: own_addr = val[6:0];
			REG_STRETCH:  stretch = val[9:0];
			REG_TABLE:    tbl_bytes = val;
			default: ;
		endcase
	endfunction

	function void to_start();
		phase = PH_START;
		kind = KIND_ADDR;
		off_written = 0;
		addressed = 0;
		ack = 0;
	endfunction

	function void to_idle();
		to_start();
		phase = PH_IDLE;
		offset = '0;
	endfunction

	// low half of bit b; a read byte is fetched from the table at bit 0
	function void to_low(int b);
		phase = PH_BIT0 + 5'(2 * b);
		count = stretch;
		if (b == 0)
			shreg = (kind == KIND_READ) ? tbl_bytes[8 * offset +: 8] : 8'h00;
	endfunction

	function res_t predict(bit scl, bit sda);
		res_t r;
		bit   lscl;
		bit   lsda;
		int   b;
		r = '0;
		lscl = last_lines[1];
		lsda = last_lines[0];
		if (phase == PH_IDLE) begin
			// a start needs both lines high on the previous sample
			if (last_lines == 2'b11 && !(scl && sda)) begin
				if (scl && !sda) begin
					to_start();
					r.bus_event = EV_START;
				end else begin
					r.bus_event = EV_ERROR;
				end
			end
		end else if (phase == PH_START) begin
			if (!scl && !sda) begin
				to_low(0);
			end else if (scl && sda) begin
				to_idle();
				r.bus_event = EV_STOP;
			end else if (!scl && sda) begin
				to_idle();
				r.bus_event = EV_ERROR;
			end
		end else if (phase <= PH_ACK_HIGH) begin
			b = (phase - PH_BIT0) >> 1;
			if (!phase[0]) begin
				// clock low half: stretch first, then wait for the rise
				if (count != 0) begin
					count--;
				end else if (scl) begin
					phase++;
					if (b < 8) begin
						if (kind != KIND_READ && sda)
							shreg[7 - b] = 1'b1;
					end else begin
						if (kind == KIND_READ) begin
							ack = !sda;
							if (ack)
								offset = offset + 3'd1;
						end else if (kind == KIND_WRITE) begin
							off_written = 1;
						end
						r.byte_done  = 1'b1;
						r.byte_value = shreg;
						r.byte_kind  = kind;
						r.byte_acked = ack;
					end
				end
			end else begin
				// clock high half: falling edge or start/stop
				if (!scl) begin
					if (b < 7) begin
						to_low(b + 1);
					end else if (b == 7) begin
						case (kind)
							KIND_ADDR: begin
								ack = (shreg[7:1] == own_addr);
								if (ack)
									addressed = 1;
							end
							KIND_WRITE: begin
								ack = !off_written && (shreg < TABLE_DEPTH);
								if (ack)
									offset = shreg[2:0];
							end
							default: ack = 0;
						endcase
						to_low(8);
					end else if (kind == KIND_ADDR) begin
						if (!addressed) begin
							phase = PH_IGNORE;
						end else begin
							kind = shreg[0] ? KIND_READ : KIND_WRITE;
							to_low(0);
						end
					end else begin
						// a refused read turns the rest into writes
						if (kind == KIND_READ && !ack)
							kind = KIND_WRITE;
						to_low(0);
					end
				end else if (lscl && lsda != sda) begin
					if (lsda) begin
						to_start();
						r.bus_event = EV_START;
					end else begin
						to_idle();
						r.bus_event = EV_STOP;
					end
				end
			end
		end else begin
			// released after a mismatch: only start or stop count
			if (lscl && scl && lsda != sda) begin
				if (lsda) begin
					to_start();
					r.bus_event = EV_START;
				end else begin
					to_idle();
					r.bus_event = EV_STOP;
				end
			end
		end

		// line drives for the phase now in effect
		if (phase >= PH_BIT0 && phase <= PH_ACK_HIGH) begin
			b = (phase - PH_BIT0) >> 1;
			if (b < 8) begin
				if (kind == KIND_READ)
					r.sda_pull_low = !shreg[7 - b];
			end else if (kind != KIND_READ) begin
				r.sda_pull_low = ack;
			end
			if (!phase[0] && count != 0)
				r.scl_hold_low = 1'b1;
		end
		last_lines = {scl, sda};
		return r;
	endfunction

	function void note_word(bit scl, bit sda);
		res_t r;
		r = predict(scl, sda);
		pending.push_back(r);
		n_words++;
		if (r.byte_done)
			n_bytes[int'(r.byte_kind)]++;
		n_events[int'(r.bus_event)]++;
	endfunction

	function void compare(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	function void check_word(res_t got);
		res_t want;
		if (pending.size() == 0) begin
			$display("%0t: output word %h with nothing expected", $time, got);
			n_errors++;
			return;
		end
		want = pending.pop_front();
		compare("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
		compare("scl_hold_low", want.scl_hold_low, got.scl_hold_low);
		compare("byte_done", want.byte_done, got.byte_done);
		compare("byte_value", want.byte_value, got.byte_value);
		compare("byte_kind", want.byte_kind, got.byte_kind);
		compare("byte_acked", want.byte_acked, got.byte_acked);
		compare("bus_event", want.bus_event, got.bus_event);
	endfunction
endclass

module testbench;
	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	byte_table_scoreboard sb = new();
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   stall_cycles = 0;
	bit   cur_scl = 1'b1;
	bit   cur_sda = 1'b1;
	res_t seen;

	i2c_target_byte_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.sda_pull_low = m_tdata[0];
			seen.scl_hold_low = m_tdata[1];
			seen.byte_done    = m_tdata[2];
			seen.byte_value   = m_tdata[10:3];
			seen.byte_acked   = m_tdata[11];
			seen.bus_event    = event_t'(m_tdata[13:12]);
			seen.byte_kind    = kind_t'(m_tuser);
			sb.check_word(seen);
		end
	end

	// watchdog on cycles with no word or register access accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one line sample word, with random sender gaps
	task automatic send_word(input bit scl, input bit sda);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, sda, scl};
		cur_scl = scl;
		cur_sda = sda;
		do @(posedge clk); while (!s_tready);
		sb.note_word(scl, sda);
	endtask

	// stop sending until every expected word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, then read it back
	task automatic reg_set(input logic [1:0] idx, input logic [63:0] val);
		logic [63:0] mask;
		mask = (idx == REG_OWN_ADDR) ? 64'h7F : (idx == REG_STRETCH) ? 64'h3FF : '1;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask)) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, idx, val & mask, prdata & mask);
			sb.n_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// clock low samples: usually past the stretch, now and then rising inside it
	function automatic int low_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(1, sb.stretch + 1);
		return sb.stretch + $urandom_range(1, 3);
	endfunction

	task automatic clock_bit(input bit v);
		int n;
		n = low_len();
		// data mostly changes after the fall, sometimes together with it
		send_word(1'b0, ($urandom_range(7) == 0) ? v : cur_sda);
		repeat (n - 1) send_word(1'b0, v);
		repeat ($urandom_range(1, 3)) send_word(1'b1, v);
	endtask

	task automatic xfer_byte(input logic [7:0] v, input bit ack_line);
		for (int i = 7; i >= 0; i--)
			clock_bit(v[i]);
		clock_bit(ack_line);
	endtask

	// start or repeated start
	task automatic start_cond();
		if (!(cur_scl && cur_sda)) begin
			if (cur_scl)
				send_word(1'b0, cur_sda);
			repeat (low_len()) send_word(1'b0, 1'b1);
			repeat ($urandom_range(1, 3)) send_word(1'b1, 1'b1);
		end
		repeat ($urandom_range(1, 2)) send_word(1'b1, 1'b0);
	endtask

	task automatic stop_cond();
		if (cur_scl)
			send_word(1'b0, cur_sda);
		repeat (low_len()) send_word(1'b0, 1'b0);
		repeat ($urandom_range(1, 3)) send_word(1'b1, 1'b0);
		repeat ($urandom_range(1, 3)) send_word(1'b1, 1'b1);
	endtask

	task automatic write_offset(input logic [6:0] addr, input logic [7:0] off, input int extra);
		start_cond();
		xfer_byte({addr, 1'b0}, 1'b1);
		xfer_byte(off, 1'b1);
		repeat (extra) xfer_byte(8'($urandom), 1'($urandom));
	endtask

	// controller acks every byte but the last; more bytes after that are taken as writes
	task automatic read_bytes(input logic [6:0] addr, input int num, input int after_nack);
		start_cond();
		xfer_byte({addr, 1'b1}, 1'b1);
		for (int i = 0; i < num; i++)
			xfer_byte(8'($urandom), i == num - 1);
		repeat (after_nack) xfer_byte(8'($urandom), 1'($urandom));
	endtask

	task automatic random_txn();
		logic [6:0] addr;
		int pick;
		addr = ($urandom_range(99) < 85) ? sb.own_addr : 7'($urandom);
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: begin
				write_offset(addr,
					($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
					($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
				if ($urandom_range(1))
					read_bytes(addr, $urandom_range(1, 3), 0);
			end
			4, 5, 6: begin
				read_bytes(addr, $urandom_range(1, 4), ($urandom_range(4) == 0));
			end
			7: begin
				write_offset(sb.own_addr ^ 7'($urandom_range(1, 127)), 8'($urandom), 1);
			end
			8: begin
				// abandon a byte part way through
				start_cond();
				xfer_byte({sb.own_addr, 1'($urandom)}, 1'b1);
				repeat ($urandom_range(1, 8)) clock_bit(1'($urandom));
				if ($urandom_range(1))
					start_cond();
			end
			default: begin
				repeat ($urandom_range(4, 16)) send_word(1'($urandom), 1'($urandom));
			end
		endcase
		if ($urandom_range(9) < 7)
			stop_cond();
	endtask

	initial begin
		int goal;
		bit paused;
		paused = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle lines left without a proper start
		send_word(1'b0, 1'b1);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b1);
		// start then stop at once, start then data rising with clock low
		send_word(1'b1, 1'b0);
		send_word(1'b1, 1'b1);
		send_word(1'b1, 1'b0);
		send_word(1'b0, 1'b1);
		send_word(1'b1, 1'b1);

		// reset settings: one read with the default stretch
		read_bytes(OWN_ADDR_RST, 1, 0);
		stop_cond();

		// no stretch: offset write with wrap, refused offset, mismatch
		drain();
		reg_set(REG_STRETCH, 64'h0);
		write_offset(OWN_ADDR_RST, 8'd5, 1);
		read_bytes(OWN_ADDR_RST, 4, 1);
		stop_cond();
		write_offset(OWN_ADDR_RST, 8'd9, 0);
		stop_cond();
		write_offset(OWN_ADDR_RST ^ 7'h01, 8'h00, 1);
		stop_cond();
		// stop and repeated start inside a byte
		start_cond();
		xfer_byte({OWN_ADDR_RST, 1'b0}, 1'b1);
		repeat (3) clock_bit(1'b1);
		stop_cond();
		start_cond();
		repeat (5) clock_bit(1'b0);
		start_cond();
		stop_cond();

		// low extremes: address zero, empty table
		drain();
		reg_set(REG_OWN_ADDR, 64'h0);
		reg_set(REG_TABLE, 64'h0);
		write_offset(7'h00, 8'd7, 0);
		read_bytes(7'h00, 2, 0);
		stop_cond();

		// high extremes: top address, all-ones table, longest stretch held by readback
		drain();
		reg_set(REG_OWN_ADDR, 64'h7F);
		reg_set(REG_TABLE, '1);
		read_bytes(7'h7F, 1, 0);
		stop_cond();
		drain();
		reg_set(REG_STRETCH, 64'h3FF);

		// random traffic in three idling modes
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 49 : 0;
			recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 22 : 0;
			reg_set(REG_OWN_ADDR, 64'($urandom));
			reg_set(REG_STRETCH, 64'($urandom_range(3)));
			reg_set(REG_TABLE, {$urandom, $urandom});
			goal = sb.n_words + 120;
			while (sb.n_words < goal) begin
				random_txn();
				if (ph == 1 && !paused && sb.n_words > goal - 60) begin
					drain();
					paused = 1;
				end
			end
			stop_cond();
		end
		drain();

		$display("run covered %0d line samples with %0d address, %0d write and %0d read bytes",
			sb.n_words, sb.n_bytes[KIND_ADDR], sb.n_bytes[KIND_WRITE], sb.n_bytes[KIND_READ]);
		$display("bus events: %0d starts, %0d stops, %0d protocol errors; stretch 0 to 10 on the bus",
			sb.n_events[EV_START], sb.n_events[EV_STOP], sb.n_events[EV_ERROR]);
		if (sb.n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2ctbt_pkg.sv
rtl/i2ctbt_regs.sv
rtl/i2ctbt_engine.sv
rtl/i2c_target_byte_table_unit.sv
rtl/i2ctbt_checker.sv
dv/testbench.sv
